/* rtl/line_position_pid_steering_macros.svh */
// Assertion macros shared by the steering controller modules.
`ifndef LINE_POSITION_PID_STEERING_MACROS_SVH
`define LINE_POSITION_PID_STEERING_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lpps_pkg.sv */
// Shared constants, types and helpers of the line position steering controller.
package lpps_pkg;

  localparam int WINDOW_DEPTH = 16;

  localparam int DATA_W    = 16;
  localparam int FRAC_W    = 8;
  localparam int SLOT_W    = $clog2(WINDOW_DEPTH);
  localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W     = DATA_W + $clog2(WINDOW_DEPTH);
  localparam int ITER_W    = $clog2(SUM_W);
  localparam int DERIV_W   = DATA_W + 1;
  localparam int PROD_W    = DATA_W + DERIV_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int CORR_W    = ACC_W - FRAC_W;
  localparam int EFF_W     = CORR_W + 1;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 2'd0,
    REG_INTEG_GAIN = 2'd1,
    REG_DERIV_GAIN = 2'd2,
    REG_BASE_SPEED = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } ring_req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]   sum;
    logic [CNT_W-1:0]          count;
    logic signed [DERIV_W-1:0] deriv;
  } ring_sts_t;

  typedef struct packed {
    logic                      clr;
    logic                      en;
    logic signed [DATA_W-1:0]  a;
    logic signed [DERIV_W-1:0] b;
  } mac_req_t;

  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [EFF_W-1:0] x);
    logic signed [DATA_W-1:0] res;
    if (x > EFF_W'(32767)) begin
      res = 16'sh7fff;
    end else if (x < -EFF_W'(32768)) begin
      res = 16'sh8000;
    end else begin
      res = x[DATA_W-1:0];
    end
    return res;
  endfunction

endpackage

/* rtl/lpps_ring.sv */
// Error window store: ring memory, running sum, slot pointer, fill flag and prior error.
`include "line_position_pid_steering_macros.svh"

module lpps_ring (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lpps_pkg::ring_req_t              req,
  input  logic signed [lpps_pkg::DATA_W-1:0] err,
  output lpps_pkg::ring_sts_t              sts
);
  import lpps_pkg::*;

  logic signed [DATA_W-1:0]  mem [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0]   valid_r;
  logic signed [DATA_W-1:0]  rd_data_r;
  logic                      rd_valid_r;
  logic [SLOT_W-1:0]         slot_r;
  logic                      filled_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [DATA_W-1:0]  prior_r;
  logic [CNT_W-1:0]          count_r;
  logic signed [DERIV_W-1:0] deriv_r;

  logic signed [DATA_W-1:0]  old_err;
  logic signed [SUM_W-1:0]   sum_nxt;
  logic [CNT_W-1:0]          count_nxt;
  logic signed [DERIV_W-1:0] deriv_nxt;
  logic                      last_slot;

  // An entry never written since reset reads as zero through its valid bit.
  assign old_err   = rd_valid_r ? rd_data_r : '0;
  assign sum_nxt   = sum_r - SUM_W'(old_err) + SUM_W'(err);
  assign deriv_nxt = DERIV_W'(prior_r) - DERIV_W'(err);
  assign count_nxt = filled_r ? CNT_W'(WINDOW_DEPTH) : CNT_W'(slot_r) + CNT_W'(1);
  assign last_slot = (slot_r == SLOT_W'(WINDOW_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[slot_r] <= err;
    end
    if (req.rd) begin
      rd_data_r <= mem[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
      slot_r     <= '0;
      filled_r   <= 1'b0;
      sum_r      <= '0;
      prior_r    <= '0;
    end else begin
      if (req.rd) begin
        rd_valid_r <= valid_r[slot_r];
      end
      if (req.wr) begin
        valid_r[slot_r] <= 1'b1;
        sum_r           <= sum_nxt;
        prior_r         <= err;
        if (last_slot) begin
          slot_r   <= '0;
          filled_r <= 1'b1;
        end else begin
          slot_r <= slot_r + SLOT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr) begin
      count_r <= count_nxt;
      deriv_r <= deriv_nxt;
    end
  end

  assign sts.sum   = sum_r;
  assign sts.count = count_r;
  assign sts.deriv = deriv_r;

  // The write back must follow the read of the same slot directly.
  `LPPS_ASSERT_NEXT(a_rd_then_wr, req.rd, req.wr && !req.rd, "ring read not followed by write")

endmodule

/* rtl/lpps_div.sv */
// Serial restoring divider for the window mean, truncating toward zero.
`include "line_position_pid_steering_macros.svh"

module lpps_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [lpps_pkg::SUM_W-1:0] dividend,
  input  logic [lpps_pkg::CNT_W-1:0]        divisor,
  output logic                              done,
  output logic signed [lpps_pkg::SUM_W-1:0] quotient
);
  import lpps_pkg::*;

  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  divisor_r;
  logic              neg_r;
  logic [ITER_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [SUM_W-1:0]  magnitude;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic              fits;

  assign magnitude = dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
  assign shifted   = {rem_r, quo_r[SUM_W-1]};
  assign diff      = shifted - {1'b0, divisor_r};
  assign fits      = (shifted >= {1'b0, divisor_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + ITER_W'(1);
        if (cnt_r == ITER_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r     <= magnitude;
      rem_r     <= '0;
      divisor_r <= divisor;
      neg_r     <= dividend[SUM_W-1];
    end else if (busy_r) begin
      // The remainder stays below the divisor, so the difference fits CNT_W bits.
      rem_r <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo_r <= {quo_r[SUM_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(quo_r) : $signed(quo_r);

  `LPPS_ASSERT_SAME(a_no_restart, start, !busy_r, "divider started while busy")

endmodule

/* rtl/lpps_mac.sv */
// Shared signed multiplier with a product register and a running accumulator.
module lpps_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lpps_pkg::mac_req_t                req,
  output logic signed [lpps_pkg::ACC_W-1:0] acc
);
  import lpps_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_v_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  addend;

  assign addend = prod_v_r ? ACC_W'(prod_r) : '0;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= PROD_W'($signed(req.a) * $signed(req.b));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      acc_r    <= '0;
    end else begin
      prod_v_r <= req.en;
      acc_r    <= req.clr ? '0 : acc_r + addend;
    end
  end

  assign acc = acc_r;

endmodule

/* rtl/line_position_pid_steering.sv */
// Top level of the line position steering controller with a windowed integral term.
//
// Usage: one item on the in_ channel is one control tick, a line position error
// and a speed modifier. Each item yields exactly one item on the out_ channel with
// the left and right motor efforts, saturated to 16 bits.
// Gains and base speed are written through the cfg_ port while the block is idle.
// Each item takes a single read-modify-write of the error ring, then the serial mean
// divider, which makes one quotient bit per cycle, then the shared multiplier, which
// forms and sums the proportional, integral and derivative products in turn. A new
// item is taken only once the previous result has been loaded into the output register.
// in_ready is high whenever no item is in flight, also while a result waits.
// If the receiver stalls, the finished result is held in the output register
// and the next item still runs; its result waits until the register is free.
// Reset clears the control and configuration registers, the window sum and the
// per-entry valid bits, so the ring reads as zero at once; no clearing pass is needed.
`include "line_position_pid_steering_macros.svh"

module line_position_pid_steering (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [lpps_pkg::DATA_W-1:0]  in_line_position,
  input  logic signed [lpps_pkg::DATA_W-1:0]  in_speed_modifier,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lpps_pkg::DATA_W-1:0]  out_left_effort,
  output logic signed [lpps_pkg::DATA_W-1:0]  out_right_effort,
  input  logic                                cfg_we,
  input  logic [lpps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lpps_pkg::DATA_W-1:0]         cfg_wdata
);
  import lpps_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_UPD   = 9'b000000010,
    ST_DST   = 9'b000000100,
    ST_DIV   = 9'b000001000,
    ST_MP    = 9'b000010000,
    ST_MI    = 9'b000100000,
    ST_MD    = 9'b001000000,
    ST_FLUSH = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [DATA_W-1:0] prop_gain_r;
  logic signed [DATA_W-1:0] integ_gain_r;
  logic signed [DATA_W-1:0] deriv_gain_r;
  logic signed [DATA_W-1:0] base_speed_r;
  logic signed [DATA_W-1:0] err_r;
  logic signed [DATA_W-1:0] mod_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] left_r;
  logic signed [DATA_W-1:0] right_r;

  logic                     accept;
  logic                     out_free;
  ring_req_t                ring_req;
  ring_sts_t                ring_sts;
  mac_req_t                 mac_req;
  logic                     div_start;
  logic                     div_done;
  logic signed [SUM_W-1:0]  div_q;
  logic signed [DATA_W-1:0] mean;
  logic signed [ACC_W-1:0]  acc;

  logic signed [CORR_W-1:0]  corr;
  logic signed [DERIV_W-1:0] base;
  logic signed [EFF_W-1:0]   left_full;
  logic signed [EFF_W-1:0]   right_full;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= '0;
      integ_gain_r <= '0;
      deriv_gain_r <= '0;
      base_speed_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PROP_GAIN:  prop_gain_r  <= cfg_wdata;
        REG_INTEG_GAIN: integ_gain_r <= cfg_wdata;
        REG_DERIV_GAIN: deriv_gain_r <= cfg_wdata;
        REG_BASE_SPEED: base_speed_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err_r <= in_line_position;
      mod_r <= in_speed_modifier;
    end
  end

  // One item at a time: the ring write of an item lands before the next read,
  // so the same slot is never read and written in overlapping accesses.
  assign ring_req.rd = accept;
  assign ring_req.wr = (state_r == ST_UPD);

  lpps_ring u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ring_req),
    .err   (err_r),
    .sts   (ring_sts)
  );

  assign div_start = (state_r == ST_DST);

  lpps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ring_sts.sum),
    .divisor  (ring_sts.count),
    .done     (div_done),
    .quotient (div_q)
  );

  assign mean = div_q[DATA_W-1:0];

  always_comb begin
    mac_req.clr = 1'b0;
    mac_req.en  = 1'b0;
    mac_req.a   = prop_gain_r;
    mac_req.b   = DERIV_W'(err_r);
    case (state_r)
      ST_MP: begin
        mac_req.clr = 1'b1;
        mac_req.en  = 1'b1;
      end
      ST_MI: begin
        mac_req.en = 1'b1;
        mac_req.a  = integ_gain_r;
        mac_req.b  = DERIV_W'(mean);
      end
      ST_MD: begin
        mac_req.en = 1'b1;
        mac_req.a  = deriv_gain_r;
        mac_req.b  = ring_sts.deriv;
      end
      default: ;
    endcase
  end

  lpps_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .acc   (acc)
  );

  // The arithmetic shift floors the Q27.8 sum toward minus infinity.
  assign corr       = CORR_W'(acc >>> FRAC_W);
  assign base       = DERIV_W'(base_speed_r) - DERIV_W'(mod_r);
  assign left_full  = (err_r < 0) ? EFF_W'(base) - EFF_W'(corr) : EFF_W'(base);
  assign right_full = (err_r > 0) ? EFF_W'(base) + EFF_W'(corr) : EFF_W'(base);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_DST;
      ST_DST:   state_nxt = ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_MP;
      ST_MP:    state_nxt = ST_MI;
      ST_MI:    state_nxt = ST_MD;
      ST_MD:    state_nxt = ST_FLUSH;
      ST_FLUSH: state_nxt = ST_FIN;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_FIN) && out_free) begin
      left_r  <= sat16(left_full);
      right_r <= sat16(right_full);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left_effort  = left_r;
  assign out_right_effort = right_r;

  `LPPS_ASSERT_NEXT(a_accept_to_upd, accept, state_r == ST_UPD, "accepted item did not start update")
  `LPPS_ASSERT_SAME(a_div_done_in_div, div_done, state_r == ST_DIV, "divider finished outside wait")
  `LPPS_ASSERT_NEXT(a_fin_loads_out, (state_r == ST_FIN) && out_free, out_valid_r && (state_r == ST_IDLE), "result not loaded")

endmodule
